// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the queue RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted (active low).
`define SPQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("queue assertion failed");

// Same check, also evaluated during reset.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("queue assertion failed");

`endif

// ===== hdl/spq_pkg.sv =====
// Package for the sorted priority task queue: sizes, operation type and cell control type.
// No dependencies.
package spq_pkg;

    localparam int DEPTH    = 16;
    localparam int ID_BITS  = 4;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } op_t;

    typedef struct packed {
        logic               ins;
        logic               pop;
        logic [ID_BITS-1:0] id;
    } cell_ctrl_t;

endpackage

// ===== hdl/sorted_priority_task_queue.sv =====
// Top level of the sorted priority task queue: fill counter, row of cells
// and registered result stage. Depends on spq_pkg, spq_cell, assert_macros.svh.
//
//  channel | dir | ports               | payload
//  s_      | in  | s_tvalid/tready     | s_tdata: op, task_id
//  m_      | out | m_tvalid/tready     | m_tdata: pop/head/occupancy/flags
//
//  One item per cycle: every cell compares and shifts in the accept cycle.
//  The result is registered and appears in the cycle after the item is accepted.
//  A new item is taken while a result waits only if m_tready is high.
//  aresetn (sync, low) clears the fill count and the result valid.
`include "assert_macros.svh"

module sorted_priority_task_queue import spq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] op, [4:1] task_id, [7:5] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [0] popped_valid, [4:1] popped_id, [5] head_valid,
                                   // [9:6] head_id, [14:10] occupancy, [15] duplicate,
                                   // [16] overflow, [23:17] zero
);

    localparam int OUT_BITS = 2 * ID_BITS + CNT_BITS + 4;

    logic                accept;
    op_t                 op;
    logic [ID_BITS-1:0]  task_id;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                full, empty;
    logic                ins_ok, pop_ok;
    cell_ctrl_t          ctrl;

    logic [ID_BITS-1:0]  entry [DEPTH];
    logic [DEPTH-1:0]    ge;
    logic [DEPTH-1:0]    eq;
    logic [DEPTH-1:0]    occ;

    logic [ID_BITS-1:0]  head_next;
    logic                head_valid;
    logic [OUT_BITS-1:0] res_next;
    logic [OUT_BITS-1:0] res_reg;
    logic                m_valid_reg, m_valid_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op       = op_t'(s_tdata[0]);
    assign task_id  = s_tdata[ID_BITS:1];

    assign full   = (count_reg == CNT_BITS'(DEPTH));
    assign empty  = (count_reg == '0);
    assign ins_ok = accept && (op == OP_INSERT) && !full;
    assign pop_ok = accept && (op == OP_POP) && !empty;

    assign ctrl.ins = ins_ok;
    assign ctrl.pop = pop_ok;
    assign ctrl.id  = task_id;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            assign occ[i] = (count_reg > CNT_BITS'(i));
            spq_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .occ         (occ[i]),
                .left_ge     ((i == 0) ? 1'b0 : ge[(i == 0) ? 0 : i - 1]),
                .left_entry  ((i == 0) ? task_id : entry[(i == 0) ? 0 : i - 1]),
                .right_entry ((i == DEPTH - 1) ? entry[i] :
                              entry[(i == DEPTH - 1) ? i : i + 1]),
                .ge          (ge[i]),
                .eq          (eq[i]),
                .entry       (entry[i])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (ins_ok) begin
            count_next = count_reg + 1'b1;
        end else if (pop_ok) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb begin
        head_next = entry[0];
        if (pop_ok) begin
            head_next = entry[1];
        end else if (ins_ok && !ge[0]) begin
            head_next = task_id;
        end
    end

    assign head_valid = (count_next != '0);

    always_comb begin
        res_next = '0;
        res_next[0]                                   = pop_ok;
        res_next[ID_BITS:1]                           = pop_ok ? entry[0] : '0;
        res_next[ID_BITS+1]                           = head_valid;
        res_next[2*ID_BITS+1:ID_BITS+2]               = head_valid ? head_next : '0;
        res_next[2*ID_BITS+CNT_BITS+1:2*ID_BITS+2]    = count_next;
        res_next[2*ID_BITS+CNT_BITS+2]                = ins_ok && (|eq);
        res_next[2*ID_BITS+CNT_BITS+3]                = accept && (op == OP_INSERT) && full;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = 24'(res_reg);

    `SPQ_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_BITS'(DEPTH))
    `SPQ_ASSERT(a_pop_dec, aclk, aresetn,
        pop_ok |=> (count_reg == $past(count_reg) - 1'b1))
    `SPQ_ASSERT(a_ovf_hold, aclk, aresetn,
        (accept && (op == OP_INSERT) && full) |=> $stable(count_reg))
    `SPQ_ASSERT(a_flags_excl, aclk, aresetn,
        m_valid_reg |-> !(res_reg[0] && res_reg[2*ID_BITS+CNT_BITS+3]))

endmodule

// ===== hdl/spq_cell.sv =====
// One queue slot: holds an identifier, compares it against the incoming one
// and takes that one or shifts from its left or right neighbor. Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
    input  logic               aclk,
    input  cell_ctrl_t         ctrl,
    input  logic               occ,
    input  logic               left_ge,
    input  logic [ID_BITS-1:0] left_entry,
    input  logic [ID_BITS-1:0] right_entry,
    output logic               ge,
    output logic               eq,
    output logic [ID_BITS-1:0] entry
);

    logic [ID_BITS-1:0] entry_reg;
    logic [ID_BITS-1:0] entry_next;

    assign ge    = occ && (entry_reg >= ctrl.id);
    assign eq    = occ && (entry_reg == ctrl.id);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins) begin
            if (!ge) begin
                entry_next = left_ge ? ctrl.id : left_entry;
            end
        end else if (ctrl.pop) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ===== dv/spq_sched_tb_pkg.sv =====
// Scoreboard for the sorted priority task queue testbench: keeps its own
// descending copy of the queue and the results still owed by the block.
// Depends on spq_pkg.
package spq_sched_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    // Packed to match m_tdata[16:0], lowest field last.
    typedef struct packed {
        logic                overflow;
        logic                duplicate;
        logic [CNT_BITS-1:0] occupancy;
        logic [ID_BITS-1:0]  head_id;
        logic                head_valid;
        logic [ID_BITS-1:0]  popped_id;
        logic                popped_valid;
    } sched_result_t;

    class sched_scoreboard;
        logic [ID_BITS-1:0] ranked[DEPTH];
        int                 fill;
        sched_result_t      awaited[$];
        int                 mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Updates the queue copy for one accepted item and owes its result.
        function void note_item(op_t op, logic [ID_BITS-1:0] id);
            sched_result_t r;
            int            pos;
            r = '0;
            if (op == OP_INSERT) begin
                if (fill >= DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < fill && ranked[pos] >= id) begin
                        if (ranked[pos] == id)
                            r.duplicate = 1'b1;
                        pos++;
                    end
                    for (int i = fill; i > pos; i--)
                        ranked[i] = ranked[i-1];
                    ranked[pos] = id;
                    fill++;
                end
            end else if (fill != 0) begin
                r.popped_valid = 1'b1;
                r.popped_id    = ranked[0];
                for (int i = 0; i + 1 < fill; i++)
                    ranked[i] = ranked[i+1];
                fill--;
            end
            r.head_valid = (fill != 0);
            r.head_id    = (fill != 0) ? ranked[0] : '0;
            r.occupancy  = CNT_BITS'(fill);
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t mismatch on %s: expected %0d, got %0d",
                             $realtime, name, want, got);
            end
        endfunction

        function void check_result(logic [23:0] beat);
            sched_result_t got;
            sched_result_t want;
            got = beat[16:0];
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t result %h arrived with nothing pending", $realtime, beat);
                return;
            end
            want = awaited.pop_front();
            compare_field("popped_valid", want.popped_valid, got.popped_valid);
            compare_field("popped_id", want.popped_id, got.popped_id);
            compare_field("head_valid", want.head_valid, got.head_valid);
            compare_field("head_id", want.head_id, got.head_id);
            compare_field("occupancy", want.occupancy, got.occupancy);
            compare_field("duplicate", want.duplicate, got.duplicate);
            compare_field("overflow", want.overflow, got.overflow);
        endfunction
    endclass

endpackage

// ===== dv/tb_sorted_priority_task_queue.sv =====
// Top-level testbench for sorted_priority_task_queue: directed inserts and pops,
// then random bursts under several idle/stall mixes, checked item by item.
// Depends on spq_pkg, spq_sched_tb_pkg and the queue RTL.
module tb_sorted_priority_task_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;
    import spq_sched_tb_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 340;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [0] op, [4:1] task_id, [7:5] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [0] popped_valid, [4:1] popped_id, [5] head_valid,
                                  // [9:6] head_id, [14:10] occupancy, [15] duplicate,
                                  // [16] overflow, [23:17] zero

    sched_scoreboard board;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_reqs    = 0;
    int hold_served  = 0;
    int hold_left    = 0;

    sorted_priority_task_queue i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // result side: check, then choose next m_tready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata);
        if (hold_served != hold_reqs) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_task(op_t op, logic [ID_BITS-1:0] id);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, id, op};
        do @(posedge aclk); while (!s_tready);
        board.note_item(op, id);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic opening_items();
        int fill_ids[DEPTH] = '{0, 15, 15, 0, 7, 8, 3, 12, 1, 14, 10, 5, 9, 2, 6, 11};
        send_task(OP_POP, 4'hF);               // empty queue, id ignored
        foreach (fill_ids[i])
            send_task(OP_INSERT, ID_BITS'(fill_ids[i]));
        send_task(OP_INSERT, 4'd4);            // full: dropped
        send_task(OP_INSERT, 4'd15);           // full, equal id present: still no dup
        send_task(OP_POP, 4'd0);
        send_task(OP_POP, 4'hF);
        send_task(OP_INSERT, 4'd13);
    endtask

    // burst with a random insert/pop mix and an optionally narrow id range
    task automatic mix_burst(int n);
        int                 ins_pct;
        int                 span;
        logic [ID_BITS-1:0] base;
        logic [ID_BITS-1:0] id;
        op_t                op;
        case ($urandom_range(2))
            0: ins_pct = 15;
            1: ins_pct = 50;
            default: ins_pct = 85;
        endcase
        span = $urandom_range(1) ? 15 : $urandom_range(3);
        base = ID_BITS'($urandom_range(15));
        for (int k = 0; k < n; k++) begin
            op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_POP;
            id = base + ID_BITS'($urandom_range(span));
            send_task(op, id);
        end
    endtask

    initial begin
        int sent;
        int n;
        bit held;
        board = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        opening_items();
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 74; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 74; end
                default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
            endcase
            sent = 0;
            held = 1'b0;
            while (sent < PHASE_ITEMS) begin
                if (!held && sent >= 120 && (phase == 0 || phase == 3)) begin
                    hold_reqs <= hold_reqs + 1;
                    held = 1'b1;
                end
                n = $urandom_range(24, 48);
                mix_burst(n);
                sent += n;
            end
            drain();
        end

        repeat (16) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
